>>> src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int          WAIT_BITS_DEF   = 10;
    localparam int          PT_W            = 10;
    localparam logic [9:0]  PHASE_TICKS_RST = 10'd10;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_STOP  = 2'd1,
        K_WRITE = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    // One time-base tick as held in the command queue.
    typedef struct packed {
        logic       has_cmd;
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } t_tick;

    // Pin and status snapshot produced for each tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_pull_low;
        logic       ready_res;
        logic       done_res;
        logic       ack_missing;
        logic [7:0] rx_byte;
    } t_result;

endpackage

>>> src/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry first-in first-out queue with full and empty flags decoded from a registered count.
// ----------------------------------------------------------------------------
module i2cm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic             o_rd_valid,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             wr;
    logic             rd;

    assign o_full     = (r_cnt == 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr         = i_wr_en && !o_full;
    assign rd         = i_rd_en && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

>>> src/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts ticks, qualifies the command fields and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd_valid,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_nack,
    input  logic       i_sda_in,
    input  logic       i_pop,
    output logic       o_tick_valid,
    output t_tick      o_tick
);

    t_tick tick;
    logic  full;

    // Fields a command does not use are zeroed so the engine sees clean data.
    always_comb begin
        tick.has_cmd   = i_cmd_valid;
        tick.kind      = t_kind'(i_kind);
        tick.sda_in    = i_sda_in;
        tick.tx_byte   = (t_kind'(i_kind) == K_WRITE) ? i_tx_byte : 8'h00;
        tick.send_nack = (t_kind'(i_kind) == K_READ) ? i_send_nack : 1'b0;
    end

    assign o_stall = full;

    i2cm_queue #(
        .WIDTH ($bits(t_tick))
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_valid),
        .i_wr_data  (tick),
        .o_full     (full),
        .i_rd_en    (i_pop),
        .o_rd_valid (o_tick_valid),
        .o_rd_data  (o_tick)
    );

endmodule

>>> src/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus phase machine: advances one step per queued tick and forms the result.
// ----------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int WAIT_BITS = WAIT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [PT_W-1:0] i_cfg_wr_data,
    input  logic            i_tick_valid,
    input  t_tick           i_tick,
    output logic            o_pop,
    input  logic            i_out_full,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam int          LIM_W = (WAIT_BITS > PT_W) ? WAIT_BITS : PT_W;
    localparam logic [LIM_W-1:0] WAIT_MAX = LIM_W'((64'd1 << WAIT_BITS) - 64'd1);

    typedef enum logic [4:0] {
        PH_IDLE, PH_S_REL, PH_S_SCLH, PH_S_SDAL, PH_S_SCLL,
        PH_P_LOW, PH_P_SCLH, PH_P_REL,
        PH_W_SETUP, PH_W_HIGH, PH_W_AREL, PH_W_AHIGH, PH_W_ALOW,
        PH_R_REL, PH_R_HIGH, PH_R_LOW, PH_R_ASET, PH_R_AHIGH, PH_R_ALOW
    } t_phase;

    logic [PT_W-1:0]      r_phase_ticks;
    t_phase               r_phase,     n_phase;
    logic [3:0]           r_bit_count, n_bit_count;
    logic [WAIT_BITS-1:0] r_wait,      n_wait;
    logic [7:0]           r_shift,     n_shift;
    t_kind                r_kind,      n_kind;
    logic                 r_nack,      n_nack;
    logic                 r_ack,       n_ack;
    logic                 r_scl,       n_scl;
    logic                 r_sda,       n_sda;
    logic [7:0]           r_rx,        n_rx;
    logic                 n_done;
    logic                 entered;
    logic [LIM_W-1:0]     pt_ext;
    logic [LIM_W-1:0]     lim;
    logic [3:0]           bit_inc;

    assign o_pop       = i_tick_valid && !i_out_full;
    assign o_res_valid = o_pop;

    assign pt_ext  = LIM_W'(r_phase_ticks);
    assign lim     = (pt_ext > WAIT_MAX) ? WAIT_MAX : pt_ext;
    assign bit_inc = r_bit_count + 4'd1;

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_wait      = r_wait;
        n_shift     = r_shift;
        n_kind      = r_kind;
        n_nack      = r_nack;
        n_ack       = r_ack;
        n_rx        = r_rx;
        n_done      = 1'b0;
        entered     = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_tick.has_cmd) begin
                n_kind      = i_tick.kind;
                n_bit_count = 4'd0;
                entered     = 1'b1;
                case (i_tick.kind)
                    K_START: n_phase = PH_S_REL;
                    K_STOP:  n_phase = PH_P_LOW;
                    K_WRITE: begin
                        n_shift = i_tick.tx_byte;
                        n_phase = PH_W_SETUP;
                    end
                    default: begin
                        n_shift = 8'h00;
                        n_nack  = i_tick.send_nack;
                        n_phase = PH_R_REL;
                    end
                endcase
            end
        end else if (LIM_W'(r_wait) < lim) begin
            n_wait = r_wait + WAIT_BITS'(1);
        end else begin
            entered = 1'b1;
            case (r_phase)
                PH_S_REL:   n_phase = PH_S_SCLH;
                PH_S_SCLH:  n_phase = PH_S_SDAL;
                PH_S_SDAL:  n_phase = PH_S_SCLL;
                PH_P_LOW:   n_phase = PH_P_SCLH;
                PH_P_SCLH:  n_phase = PH_P_REL;
                PH_W_SETUP: n_phase = PH_W_HIGH;
                PH_W_HIGH: begin
                    n_shift     = {r_shift[6:0], 1'b0};
                    n_bit_count = bit_inc;
                    n_phase     = (bit_inc >= 4'd8) ? PH_W_AREL : PH_W_SETUP;
                end
                PH_W_AREL:  n_phase = PH_W_AHIGH;
                PH_W_AHIGH: begin
                    n_ack   = i_tick.sda_in;
                    n_phase = PH_W_ALOW;
                end
                PH_R_REL:   n_phase = PH_R_HIGH;
                PH_R_HIGH: begin
                    n_shift     = {r_shift[6:0], i_tick.sda_in};
                    n_bit_count = bit_inc;
                    n_phase     = PH_R_LOW;
                end
                PH_R_LOW: begin
                    if (r_bit_count >= 4'd8) begin
                        n_rx    = r_shift;
                        n_phase = PH_R_ASET;
                    end else begin
                        n_phase = PH_R_HIGH;
                    end
                end
                PH_R_ASET:  n_phase = PH_R_AHIGH;
                PH_R_AHIGH: n_phase = PH_R_ALOW;
                default: begin
                    // Last segment of a command has run out: back to idle.
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            endcase
        end

        if (entered) begin
            n_wait = '0;
        end
    end

    // Pin levels set on entry to a segment, using the updated shift and flags.
    always_comb begin
        n_scl = r_scl;
        n_sda = r_sda;
        if (entered) begin
            case (n_phase)
                PH_S_REL:   n_sda = 1'b0;
                PH_S_SCLH:  n_scl = 1'b1;
                PH_S_SDAL:  n_sda = 1'b1;
                PH_S_SCLL:  n_scl = 1'b0;
                PH_P_LOW: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                PH_P_SCLH:  n_scl = 1'b1;
                PH_P_REL:   n_sda = 1'b0;
                PH_W_SETUP: begin
                    n_scl = 1'b0;
                    n_sda = ~n_shift[7];
                end
                PH_W_HIGH:  n_scl = 1'b1;
                PH_W_AREL: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                PH_W_AHIGH: n_scl = 1'b1;
                PH_W_ALOW:  n_scl = 1'b0;
                PH_R_REL:   n_sda = 1'b0;
                PH_R_HIGH:  n_scl = 1'b1;
                PH_R_LOW:   n_scl = 1'b0;
                PH_R_ASET:  n_sda = ~n_nack;
                PH_R_AHIGH: n_scl = 1'b1;
                PH_R_ALOW:  n_scl = 1'b0;
                default: begin
                    n_scl = r_scl;
                    n_sda = r_sda;
                end
            endcase
        end
    end

    always_comb begin
        o_res.scl_out      = n_scl;
        o_res.sda_pull_low = n_sda;
        o_res.ready_res    = (n_phase == PH_IDLE);
        o_res.done_res     = n_done;
        o_res.ack_missing  = n_ack;
        o_res.rx_byte      = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_phase       <= PH_IDLE;
            r_bit_count   <= 4'd0;
            r_wait        <= '0;
            r_shift       <= 8'h00;
            r_kind        <= K_START;
            r_nack        <= 1'b0;
            r_ack         <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b0;
            r_rx          <= 8'h00;
        end else begin
            if (i_cfg_wr_en) begin
                r_phase_ticks <= i_cfg_wr_data;
            end
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_wait      <= n_wait;
                r_shift     <= n_shift;
                r_kind      <= n_kind;
                r_nack      <= n_nack;
                r_ack       <= n_ack;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_rx        <= n_rx;
            end
        end
    end

endmodule

>>> src/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master that runs start, stop, write-byte and read-byte commands.
// ----------------------------------------------------------------------------
// Each input transfer is one time-base tick; it may carry a command, which is
// taken only while the engine is idle. SCL is driven push-pull and SDA is
// open-drain (o_sda_pull_low). Every tick yields exactly one output transfer
// with the pin levels and status after that tick.
// Ticks enter a two-entry input queue; the phase machine takes one tick per
// clock cycle from it while the output queue has room (throughput is set by
// its single step) and writes the result into a two-entry output queue. A
// tick is registered in the input queue and its result in the output queue
// before it is offered. Each bus segment lasts phase_ticks + 1 ticks, written
// through i_cfg_wr_en. Reset empties both queues, idles the bus (SCL high,
// SDA released) and sets phase_ticks to 10. When the receiver stalls, results
// collect in the output queue; once it is full the engine pauses and the
// input queue fills, after which o_stall rises. No tick is dropped or repeated.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int WAIT_BITS = WAIT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [PT_W-1:0] i_cfg_wr_data,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_cmd_valid,
    input  logic [1:0]      i_kind,
    input  logic [7:0]      i_tx_byte,
    input  logic            i_send_nack,
    input  logic            i_sda_in,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_scl_out,
    output logic            o_sda_pull_low,
    output logic            o_ready_res,
    output logic            o_done_res,
    output logic            o_ack_missing,
    output logic [7:0]      o_rx_byte
);

    logic    tick_valid;
    t_tick   tick;
    logic    pop;
    logic    out_full;
    logic    res_valid;
    t_result res;
    t_result out_res;

    i2cm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd_valid  (i_cmd_valid),
        .i_kind       (i_kind),
        .i_tx_byte    (i_tx_byte),
        .i_send_nack  (i_send_nack),
        .i_sda_in     (i_sda_in),
        .i_pop        (pop),
        .o_tick_valid (tick_valid),
        .o_tick       (tick)
    );

    i2cm_engine #(
        .WAIT_BITS (WAIT_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tick_valid  (tick_valid),
        .i_tick        (tick),
        .o_pop         (pop),
        .i_out_full    (out_full),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    i2cm_queue #(
        .WIDTH ($bits(t_result))
    ) u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (res_valid),
        .i_wr_data  (res),
        .o_full     (out_full),
        .i_rd_en    (!i_stall),
        .o_rd_valid (o_valid),
        .o_rd_data  (out_res)
    );

    assign o_scl_out      = out_res.scl_out;
    assign o_sda_pull_low = out_res.sda_pull_low;
    assign o_ready_res    = out_res.ready_res;
    assign o_done_res     = out_res.done_res;
    assign o_ack_missing  = out_res.ack_missing;
    assign o_rx_byte      = out_res.rx_byte;

endmodule
